/* rtl/core/rfns_pkg.sv */
// ----------------------------------------------------------------------------
// rfns_pkg
// Shared constants and types for the running five-number summary block.
// ----------------------------------------------------------------------------
package rfns_pkg;

  localparam int Capacity = 256;
  localparam int NumBins  = 10;
  localparam int AddrW    = $clog2(Capacity);
  localparam int CntW     = 9;
  localparam int BinW     = 4;
  localparam int DataW    = 32;
  localparam int WideW    = 40;

  localparam logic signed [WideW-1:0] QHalf = WideW'(32768);
  localparam logic signed [WideW-1:0] QStep = WideW'(65536 / NumBins);

  // Bin width by reciprocal multiply: floor(x / NumBins) for any 32-bit span
  localparam int               RecipSh  = 35;
  localparam logic [DataW-1:0] RecipMul =
    DataW'(((64'd1 << RecipSh) + 64'(NumBins) - 64'd1) / 64'(NumBins));

  // Request and result payloads
  typedef struct packed {
    logic signed [DataW-1:0] sample;
  } sample_t;

  typedef struct packed {
    logic [CntW-1:0]         sample_count;
    logic signed [DataW-1:0] minimum;
    logic signed [DataW-1:0] maximum;
    logic signed [DataW-1:0] median_value;
    logic signed [DataW-1:0] lower_quartile;
    logic signed [DataW-1:0] upper_quartile;
    logic [BinW-1:0]         bin_index;
    logic signed [DataW-1:0] bin_start;
    logic [CntW-1:0]         bin_count;
    logic                    last_bin;
    logic                    rejected;
  } summary_t;

  // Datapath operation selected by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_SHIFT_RD,   // read store[i-1]
    OP_SHIFT_CMP,  // compare / move
    OP_INSERT,
    OP_RD_A,
    OP_RD_B,
    OP_LATCH,
    OP_WIDTH,
    OP_EDGE,
    OP_HIST_RD,
    OP_HIST_ACC
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [AddrW-1:0] addr;
    logic [2:0]       slot;   // which statistic is being gathered
  } cmd_t;

  typedef struct packed {
    logic move;     // store[i-1] > sample
    logic div_done;
  } status_t;

endpackage

/* rtl/core/rfns_if.sv */
// ----------------------------------------------------------------------------
// rfns_if
// Valid/ready channel with a generic payload type.
// ----------------------------------------------------------------------------
interface rfns_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/rfns_ram.sv */
// ----------------------------------------------------------------------------
// rfns_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module rfns_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

/* rtl/core/rfns_ctrl.sv */
// ----------------------------------------------------------------------------
// rfns_ctrl
// Sequencer: insertion, statistic reads, bin width, histogram walk, output.
// ----------------------------------------------------------------------------
module rfns_ctrl
  import rfns_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [BinW-1:0] out_bin,
  output logic [CntW-1:0] count,
  output logic            rej,
  output cmd_t            cmd,
  input  status_t         sts
);
  typedef enum logic [3:0] {
    S_IDLE, S_SRD, S_SCMP, S_INS, S_RA, S_RB, S_LATCH, S_DIV,
    S_EDGE, S_HRD, S_HACC, S_OUT
  } state_t;

  state_t           state;
  logic [CntW-1:0]  i;
  logic [2:0]       slot;
  logic [BinW-1:0]  bin;
  logic [CntW+1:0]  t;
  logic [CntW-1:0]  lo, hi, nm1;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_bin   = bin;
  assign nm1       = count - CntW'(1);

  // Slot 0/1: min/max; 2..7: lo/hi of med, q1, q3 (pairs)
  always_comb begin
    t = '0;
    unique case (slot)
      3'd2, 3'd3: t = {2'b00, nm1} << 1;
      3'd4, 3'd5: t = {2'b00, nm1};
      default:    t = {2'b00, nm1} + ({2'b00, nm1} << 1);
    endcase
    lo = CntW'(t >> 2);
    hi = CntW'((t + (CntW+2)'(3)) >> 2);
    if (lo >= count) lo = nm1;
    if (hi >= count) hi = nm1;
  end

  always_comb begin
    cmd.op   = OP_NONE;
    cmd.slot = slot;
    cmd.addr = '0;
    unique case (state)
      S_SRD:   begin cmd.op = OP_SHIFT_RD;  cmd.addr = AddrW'(i - CntW'(1)); end
      S_SCMP:  begin cmd.op = OP_SHIFT_CMP; cmd.addr = AddrW'(i); end
      S_INS:   begin cmd.op = OP_INSERT;    cmd.addr = AddrW'(i); end
      S_RA: begin
        cmd.op = OP_RD_A;
        unique case (slot)
          3'd0:    cmd.addr = '0;
          3'd1:    cmd.addr = AddrW'(nm1);
          default: cmd.addr = AddrW'(lo);
        endcase
      end
      S_RB:    begin cmd.op = OP_RD_B;      cmd.addr = AddrW'(hi); end
      S_LATCH: cmd.op = OP_LATCH;
      S_DIV:   cmd.op = OP_WIDTH;
      S_EDGE:  cmd.op = OP_EDGE;
      S_HRD:   begin cmd.op = OP_HIST_RD;   cmd.addr = AddrW'(i); end
      S_HACC:  cmd.op = OP_HIST_ACC;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      rej   <= 1'b0;
      i     <= '0;
      slot  <= '0;
      bin   <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          rej <= (count >= CntW'(Capacity));
          i   <= count;
          if (count >= CntW'(Capacity)) begin
            slot <= '0; state <= S_RA;
          end else if (count == '0) state <= S_INS;
          else state <= S_SRD;
        end
        S_SRD:  state <= S_SCMP;
        S_SCMP: if (sts.move) begin
          i <= i - CntW'(1);
          state <= (i == CntW'(1)) ? S_INS : S_SRD;
        end else state <= S_INS;
        S_INS: begin
          count <= count + CntW'(1);
          slot  <= '0;
          state <= S_RA;
        end
        S_RA:   state <= (slot >= 3'd2) ? S_RB : S_LATCH;
        S_RB:   state <= S_LATCH;
        S_LATCH: begin
          if (slot == 3'd0) slot <= 3'd1;
          else if (slot == 3'd1) slot <= 3'd2;
          else slot <= slot + 3'd2;
          state <= (slot == 3'd6) ? S_DIV : S_RA;
        end
        S_DIV: if (sts.div_done) begin bin <= '0; state <= S_EDGE; end
        S_EDGE: begin
          i <= '0;
          state <= S_HRD;
        end
        S_HRD:  state <= S_HACC;
        S_HACC: begin
          i <= i + CntW'(1);
          state <= (i + CntW'(1) == count) ? S_OUT : S_HRD;
        end
        S_OUT: if (out_ready) begin
          if (bin == BinW'(NumBins - 1)) begin
            bin   <= '0;
            state <= S_IDLE;
          end else begin
            bin <= bin + BinW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/core/rfns_dp.sv */
// ----------------------------------------------------------------------------
// rfns_dp
// Datapath: sorted store, statistic registers, bin width multiply, bin counts.
// ----------------------------------------------------------------------------
module rfns_dp
  import rfns_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output status_t                 sts,
  input  logic                    in_take,
  input  logic signed [DataW-1:0] sample,
  input  logic [BinW-1:0]         out_bin,
  output logic signed [DataW-1:0] mn,
  output logic signed [DataW-1:0] mx,
  output logic signed [DataW-1:0] med,
  output logic signed [DataW-1:0] q1,
  output logic signed [DataW-1:0] q3,
  output logic signed [DataW-1:0] bin_start,
  output logic [CntW-1:0]         bin_count
);
  logic                    we;
  logic signed [DataW-1:0] wdata, rdata, smp, ra;
  logic signed [DataW:0]   hsum;
  logic signed [WideW-1:0] base, w, edge_acc;
  logic signed [WideW-1:0] edges [NumBins];
  logic [CntW-1:0]         cnt [NumBins];
  logic [NumBins-1:0]      hit;
  logic                    placed;
  // (mx-mn)/NumBins by reciprocal multiply, span is non-negative
  logic [DataW-1:0]        span;
  logic [2*DataW-1:0]      prod;
  logic [1:0]              dstep;
  logic                    div_run;
  logic [BinW-1:0]         ebin;

  rfns_ram #(.Width(DataW), .Depth(Capacity)) u_store (
    .clk(clk), .we(we), .addr(cmd.addr), .wdata(wdata), .rdata(rdata)
  );

  assign we    = (cmd.op == OP_INSERT) || (cmd.op == OP_SHIFT_CMP && sts.move);
  assign wdata = (cmd.op == OP_INSERT) ? smp : rdata;
  assign sts.move = (rdata > smp);
  assign sts.div_done = div_run && (dstep == 2'd0) && (ebin == BinW'(NumBins - 1));
  assign hsum  = {ra[DataW-1], ra} + {rdata[DataW-1], rdata};

  // which bin a stored value falls in
  always_comb begin
    hit = '0;
    placed = 1'b0;
    for (int j = 0; j < NumBins - 1; j++) begin
      if (!placed && WideW'(rdata) >= edges[j] && WideW'(rdata) < edges[j+1]) begin
        hit[j] = 1'b1;
        placed = 1'b1;
      end
    end
    if (!placed) hit[NumBins-1] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_run <= 1'b0;
      dstep   <= '0;
      ebin    <= '0;
    end else begin
      if (in_take) smp <= sample;
      unique case (cmd.op)
        OP_RD_A: ;
        OP_RD_B: ra <= rdata;
        OP_LATCH: begin
          unique case (cmd.slot)
            3'd0:    mn  <= rdata;
            3'd1:    mx  <= rdata;
            3'd2:    med <= DataW'(hsum >>> 1);
            3'd4:    q1  <= DataW'(hsum >>> 1);
            default: q3  <= DataW'(hsum >>> 1);
          endcase
        end
        OP_WIDTH: begin
          if (!div_run) begin
            div_run <= 1'b1;
            dstep   <= 2'd2;
            span    <= DataW'(mx - mn);
            ebin    <= '0;
            for (int j = 0; j < NumBins; j++) cnt[j] <= '0;
          end else if (dstep == 2'd2) begin
            prod  <= span * RecipMul;
            dstep <= 2'd1;
          end else if (dstep == 2'd1) begin
            dstep <= 2'd0;
            if (mx == mn) begin
              base <= WideW'(mn) - QHalf;
              w    <= QStep;
              edge_acc <= WideW'(mn) - QHalf;
            end else begin
              base <= WideW'(mn);
              w    <= WideW'({1'b0, prod[2*DataW-1:RecipSh]});
              edge_acc <= WideW'(mn);
            end
          end else if (ebin != BinW'(NumBins - 1)) begin
            // one edge per cycle
            edges[ebin] <= edge_acc;
            edge_acc    <= edge_acc + w;
            ebin        <= ebin + BinW'(1);
          end
        end
        OP_EDGE: begin
          edges[NumBins-1] <= edge_acc;
          div_run <= 1'b0;
          ebin    <= '0;
        end
        OP_HIST_ACC: begin
          for (int j = 0; j < NumBins; j++)
            if (hit[j]) cnt[j] <= cnt[j] + CntW'(1);
        end
        default: ;
      endcase
      if (cmd.op == OP_RD_A && cmd.slot < 3'd2) ra <= '0;
    end
  end

  // saturated edge of the bin on the output
  always_comb begin
    logic signed [WideW-1:0] e;
    e = edges[out_bin];
    if (e > WideW'(32'sh7fffffff)) bin_start = 32'sh7fffffff;
    else if (e < -(WideW'(33'sh080000000))) bin_start = 32'sh80000000;
    else bin_start = DataW'(e);
    bin_count = cnt[out_bin];
  end

  logic unused_base;
  assign unused_base = ^base;
endmodule

/* rtl/core/running_five_number_summary_histogram.sv */
// ----------------------------------------------------------------------------
// running_five_number_summary_histogram
// Running sorted store with five-number summary and 10-bin histogram.
// ----------------------------------------------------------------------------
// Each request adds one Q16.16 sample to a sorted store of 256 values and
// returns ten results, one per bin. An add is accepted, then runs a sorted
// insertion through the single store port with a final write, the statistic
// reads, the bin width multiply and edge steps, and the histogram walk
// before the ten output beats; a new sample is taken only after the last
// beat. A full store rejects the sample and skips the insertion.
module running_five_number_summary_histogram
  import rfns_pkg::*;
(
  input logic clk,
  input logic rst,
  rfns_if.sink   in_ch,
  rfns_if.source out_ch
);
  cmd_t            cmd;
  status_t         sts;
  logic [BinW-1:0] out_bin;
  logic [CntW-1:0] count;
  logic            rej;
  logic signed [DataW-1:0] mn, mx, med, q1, q3, bstart;
  logic [CntW-1:0] bcount;

  rfns_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_bin(out_bin),
    .count(count), .rej(rej), .cmd(cmd), .sts(sts)
  );

  rfns_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_take(in_ch.valid && in_ch.ready), .sample(in_ch.payload.sample),
    .out_bin(out_bin), .mn(mn), .mx(mx), .med(med), .q1(q1), .q3(q3),
    .bin_start(bstart), .bin_count(bcount)
  );

  assign out_ch.payload.sample_count   = count;
  assign out_ch.payload.minimum        = mn;
  assign out_ch.payload.maximum        = mx;
  assign out_ch.payload.median_value   = med;
  assign out_ch.payload.lower_quartile = q1;
  assign out_ch.payload.upper_quartile = q3;
  assign out_ch.payload.bin_index      = out_bin;
  assign out_ch.payload.bin_start      = bstart;
  assign out_ch.payload.bin_count      = bcount;
  assign out_ch.payload.last_bin       = (out_bin == BinW'(NumBins - 1));
  assign out_ch.payload.rejected       = rej;
endmodule

/* bench/tb_running_five_number_summary_histogram.sv */
// ----------------------------------------------------------------------------
// tb_running_five_number_summary_histogram
// Self-checking bench for the running five-number summary with histogram.
// Samples go in over a valid/ready channel. Each accepted request is fed
// through a behavioural model of the sorted store, which predicts the ten
// per-bin results. Every result beat is then compared field by field. Idling
// and stalling on both channels vary from phase to phase. The store is run
// until it is full, so that later samples are rejected.
// ----------------------------------------------------------------------------
module tb_running_five_number_summary_histogram;
  timeunit 1ns;
  timeprecision 1ps;

  import rfns_pkg::*;

  localparam longint QOne = 65536;
  localparam longint QHalfL = 32768;

  // Summary model: keeps its own sorted copy and queues expected beats
  class summary_scoreboard;
    longint   held[Capacity];
    int       held_n;
    summary_t pending[$];
    int       errors;

    function new();
      held_n = 0;
      errors = 0;
    endfunction

    // floor of the mean of the two entries around num/4 * (n-1)
    function longint quart(int num);
      int t;
      int lo;
      int hi;
      t  = num * (held_n - 1);
      lo = t / 4;
      hi = (t + 3) / 4;
      if (lo >= held_n) lo = held_n - 1;
      if (hi >= held_n) hi = held_n - 1;
      return (held[lo] + held[hi]) >>> 1;
    endfunction

    function void note(logic signed [DataW-1:0] s);
      bit       full;
      int       i;
      int       j;
      longint   mn;
      longint   mx;
      longint   base;
      longint   w;
      longint   e;
      longint   edges[NumBins];
      int       cnt[NumBins];
      bit       placed;
      summary_t r;
      full = (held_n >= Capacity);
      // sorted insertion
      if (!full) begin
        i = held_n;
        while (i > 0 && held[i-1] > longint'(s)) begin
          held[i] = held[i-1];
          i--;
        end
        held[i] = longint'(s);
        held_n++;
      end
      mn = held[0];
      mx = held[held_n-1];
      if (mx == mn) begin
        base = mn - QHalfL;
        w    = QOne / NumBins;
      end else begin
        base = mn;
        w    = (mx - mn) / NumBins;
      end
      for (j = 0; j < NumBins; j++) begin
        edges[j] = base + j * w;
        cnt[j]   = 0;
      end
      // histogram: first matching bin, otherwise the last one
      for (i = 0; i < held_n; i++) begin
        placed = 0;
        for (j = 0; j + 1 < NumBins && !placed; j++) begin
          if (held[i] >= edges[j] && held[i] < edges[j+1]) begin
            cnt[j]++;
            placed = 1;
          end
        end
        if (!placed) cnt[NumBins-1]++;
      end
      for (j = 0; j < NumBins; j++) begin
        e = edges[j];
        if (e > 64'sd2147483647) e = 64'sd2147483647;
        if (e < -64'sd2147483648) e = -64'sd2147483648;
        r.sample_count   = CntW'(held_n);
        r.minimum        = DataW'(mn);
        r.maximum        = DataW'(mx);
        r.median_value   = DataW'(quart(2));
        r.lower_quartile = DataW'(quart(1));
        r.upper_quartile = DataW'(quart(3));
        r.bin_index      = BinW'(j);
        r.bin_start      = DataW'(e);
        r.bin_count      = CntW'(cnt[j]);
        r.last_bin       = (j == NumBins - 1);
        r.rejected       = full;
        pending.push_back(r);
      end
    endfunction

    task report(string what, longint got, longint want);
      $display("MISMATCH %0t: %s got %0d expected %0d", $time, what, got, want);
      errors++;
    endtask

    task check(summary_t got);
      summary_t w;
      if (pending.size() == 0) begin
        report("unexpected result, bin", got.bin_index, -1);
        return;
      end
      w = pending.pop_front();
      if (got.sample_count !== w.sample_count)
        report("sample_count", got.sample_count, w.sample_count);
      if (got.minimum !== w.minimum) report("minimum", got.minimum, w.minimum);
      if (got.maximum !== w.maximum) report("maximum", got.maximum, w.maximum);
      if (got.median_value !== w.median_value)
        report("median_value", got.median_value, w.median_value);
      if (got.lower_quartile !== w.lower_quartile)
        report("lower_quartile", got.lower_quartile, w.lower_quartile);
      if (got.upper_quartile !== w.upper_quartile)
        report("upper_quartile", got.upper_quartile, w.upper_quartile);
      if (got.bin_index !== w.bin_index)
        report("bin_index", got.bin_index, w.bin_index);
      if (got.bin_start !== w.bin_start)
        report("bin_start", got.bin_start, w.bin_start);
      if (got.bin_count !== w.bin_count)
        report("bin_count", got.bin_count, w.bin_count);
      if (got.last_bin !== w.last_bin) report("last_bin", got.last_bin, w.last_bin);
      if (got.rejected !== w.rejected) report("rejected", got.rejected, w.rejected);
    endtask
  endclass

  logic clk;
  logic rst;

  rfns_if #(.payload_t(sample_t))  in_ch (clk);
  rfns_if #(.payload_t(summary_t)) out_ch (clk);

  running_five_number_summary_histogram dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  summary_scoreboard sb = new();

  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Generous run limit
  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: stall at random, or hold off for a counted stretch
  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) sb.check(out_ch.payload);
  end

  // Offer one sample request and wait until it is taken
  task automatic send_sample(logic signed [DataW-1:0] s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= s;
    do @(posedge clk); while (!in_ch.ready);
    sb.note(s);
  endtask

  // Random sample: full range, near zero, repeats of earlier values, or Q16.16 integers
  function automatic logic signed [DataW-1:0] pick_sample();
    int k;
    k = $urandom_range(99);
    if (k < 55) return $urandom;
    if (k < 75) return DataW'($urandom_range(40)) - 20;
    if (k < 90 && sb.held_n > 0)
      return DataW'(sb.held[$urandom_range(sb.held_n - 1)]);
    return DataW'(longint'($urandom_range(2000)) * QOne - 1000 * QOne);
  endfunction

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int p;
    int k;
    rst            = 1;
    in_ch.valid    = 0;
    in_ch.payload  = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: saturated low edge with all values equal, tiny spread
    // giving zero bin width, full-range spread, duplicates, extremes
    send_sample(32'sh8000_0000);
    send_sample(32'sh8000_0000);
    send_sample(32'sh8000_0005);
    send_sample(32'sh7fff_ffff);
    send_sample(32'sh7fff_ffff);
    send_sample(32'sh0000_0000);
    send_sample(-32'sd1);
    send_sample(32'sh0001_0000);
    send_sample(32'sh5555_5555);
    send_sample(32'shaaaa_aaaa);
    send_sample(32'sh0000_8000);
    send_sample(32'sh7fff_fffe);
    send_sample(32'sh8000_0001);
    send_sample(32'sh0000_0000);
    send_sample(32'sh0000_0000);
    drain();

    // Random phases with different idling, ending in a full store
    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      for (k = 0; k < 120; k++) begin
        // long hold-off while requests keep coming
        if (p == 0 && k == 30) hold_cycles = 3000;
        send_sample(pick_sample());
      end
      // sender pauses until every result is back
      drain();
    end

    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
